// ===== sv/xwm_pkg.sv =====
// Package for the wheel mixer: fixed widths, configuration codes and
// the structs that travel between the pipeline sections.
// No dependencies.
`default_nettype none
package xwm_pkg;

  // 1/sqrt(2) in Q16
  localparam logic [16:0] INV_SQRT2 = 17'd46341;

  // register indexes
  localparam logic [1:0] CFG_PRIORITY = 2'd0;
  localparam logic [1:0] CFG_OUTPUT   = 2'd1;
  localparam logic [1:0] CFG_BRAKE    = 2'd2;
  localparam logic [1:0] CFG_MV_SCALE = 2'd3;

  // priority codes (code 3 behaves as no desaturation)
  localparam logic [1:0] PRIO_KEEP_TRANS = 2'd1;
  localparam logic [1:0] PRIO_KEEP_TURN  = 2'd2;

  // output mode codes (2 and 3 leave motors unapplied)
  localparam logic [1:0] OUT_MILLIVOLT = 2'd0;
  localparam logic [1:0] OUT_PERCENT   = 2'd1;

  localparam logic [7:0] MV_SCALE_RESET = 8'd120;

  localparam logic signed [17:0] CMD_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] CMD_MIN = 18'sh20000;

  // mixer section result
  typedef struct packed {
    logic [3:0]        neg;
    logic [3:0][16:0]  mag;
    logic signed [16:0] turn;
    logic              scale;
    logic [3:0][33:0]  prod;
    logic [16:0]       peak_trans;
  } mix_t;

  // wheel translations after scaling, plus the turn
  typedef struct packed {
    logic [3:0]        neg;
    logic [3:0][16:0]  mag;
    logic signed [16:0] turn;
    logic              scale;
  } whl_t;

endpackage
`default_nettype wire

// ===== sv/xwm_mix.sv =====
// Mixer section: sums the sources, projects onto the wheel axes,
// finds peak magnitudes and picks the desaturation. Uses xwm_pkg.
`default_nettype none
module xwm_mix #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         prio_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [15:0] auton_x_i,
  input  wire logic signed [15:0] auton_y_i,
  input  wire logic signed [15:0] auton_turn_i,
  input  wire logic signed [15:0] driver_x_i,
  input  wire logic signed [15:0] driver_y_i,
  input  wire logic signed [15:0] driver_turn_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      xwm_pkg::mix_t      out_o
);

  localparam int NS = 6;
  localparam int CW = (FRACTION_BITS + 7 > 18) ? FRACTION_BITS + 8 : 19;
  localparam logic signed [CW-1:0] HUNDRED = CW'(100) << FRACTION_BITS;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // S0: sums
  logic signed [16:0] x0_q, y0_q, t0_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q <= 17'(auton_x_i) + 17'(driver_x_i);
      y0_q <= 17'(auton_y_i) + 17'(driver_y_i);
      t0_q <= 17'(auton_turn_i) + 17'(driver_turn_i);
    end
  end

  // S1: axis projection products
  logic signed [18:0] d1 [4];
  logic [17:0]        dm1 [4];
  logic [3:0]         neg1_q;
  logic [32:0]        pm1_q [4];
  logic signed [16:0] t1_q;

  always_comb begin
    d1[0] = 19'(y0_q) - 19'(x0_q);
    d1[1] = -19'(x0_q) - 19'(y0_q);
    d1[2] = 19'(x0_q) + 19'(y0_q);
    d1[3] = 19'(x0_q) - 19'(y0_q);
    for (int i = 0; i < 4; i++) begin
      dm1[i] = d1[i][18] ? 18'(-d1[i]) : 18'(d1[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        neg1_q[i] <= d1[i][18];
        pm1_q[i]  <= 33'(35'(dm1[i]) * 35'(xwm_pkg::INV_SQRT2));
      end
      t1_q <= t0_q;
    end
  end

  // S2: round to nearest
  logic [3:0]         neg2_q;
  logic [16:0]        mag2_q [4];
  logic signed [16:0] t2_q;
  logic [33:0]        rs2 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rs2[i] = 34'(pm1_q[i]) + 34'd32768;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 4; i++) mag2_q[i] <= rs2[i][32:16];
      neg2_q <= neg1_q;
      t2_q   <= t1_q;
    end
  end

  // S3: raw wheel values and peaks
  logic signed [17:0] trs3 [4];
  logic signed [18:0] raw3 [4];
  logic [17:0]        rm3 [4];
  logic [16:0]        mta, mtb, mt3;
  logic [17:0]        mra, mrb, mr3;
  logic [3:0]         neg3_q;
  logic [16:0]        mag3_q [4];
  logic signed [16:0] t3_q;
  logic [16:0]        mt3_q;
  logic [17:0]        mr3_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trs3[i] = neg2_q[i] ? -18'(mag2_q[i]) : 18'(mag2_q[i]);
      raw3[i] = 19'(trs3[i]) + 19'(t2_q);
      rm3[i]  = raw3[i][18] ? 18'(-raw3[i]) : 18'(raw3[i]);
    end
    mta = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
    mtb = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
    mt3 = (mta > mtb) ? mta : mtb;
    mra = (rm3[0] > rm3[1]) ? rm3[0] : rm3[1];
    mrb = (rm3[2] > rm3[3]) ? rm3[2] : rm3[3];
    mr3 = (mra > mrb) ? mra : mrb;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) mag3_q[i] <= mag2_q[i];
      neg3_q <= neg2_q;
      t3_q   <= t2_q;
      mt3_q  <= mt3;
      mr3_q  <= mr3;
    end
  end

  // S4: desaturation decision
  logic               over4;
  logic [16:0]        tm4;
  logic signed [CW-1:0] bt4, bk4, bt4c, bk4c;
  logic [16:0]        ntm4;
  logic signed [16:0] nt4;
  logic               sc4;
  logic [3:0]         neg4_q;
  logic [16:0]        mag4_q [4];
  logic signed [16:0] t4_q;
  logic               sc4_q;
  logic [16:0]        bud4_q;
  logic [16:0]        mt4_q;

  always_comb begin
    over4 = CW'(mr3_q) > HUNDRED;
    tm4   = t3_q[16] ? 17'(-t3_q) : 17'(t3_q);
    bt4   = HUNDRED - CW'(mt3_q);
    bt4c  = bt4[CW-1] ? '0 : bt4;
    bk4   = HUNDRED - CW'(tm4);
    bk4c  = bk4[CW-1] ? '0 : bk4;
    ntm4  = (bt4c < CW'(tm4)) ? 17'(bt4c) : tm4;
    nt4   = t3_q;
    sc4   = 1'b0;
    if (over4 && prio_i == xwm_pkg::PRIO_KEEP_TRANS) begin
      nt4 = t3_q[16] ? -17'(ntm4) : 17'(ntm4);
    end
    if (over4 && prio_i == xwm_pkg::PRIO_KEEP_TURN) begin
      sc4 = bk4c < CW'(mt3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) mag4_q[i] <= mag3_q[i];
      neg4_q <= neg3_q;
      t4_q   <= nt4;
      sc4_q  <= sc4;
      bud4_q <= 17'(bk4c);
      mt4_q  <= mt3_q;
    end
  end

  // S5: translation times budget
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int i = 0; i < 4; i++) begin
        out_o.mag[i]  <= mag4_q[i];
        out_o.prod[i] <= 34'(mag4_q[i]) * 34'(bud4_q);
      end
      out_o.neg        <= neg4_q;
      out_o.turn       <= t4_q;
      out_o.scale      <= sc4_q;
      out_o.peak_trans <= mt4_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

endmodule
`default_nettype wire

// ===== sv/xwm_div.sv =====
// Divider section: four restoring dividers, one quotient bit per stage,
// scale each wheel translation by budget over peak. Uses xwm_pkg.
`default_nettype none
module xwm_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire xwm_pkg::mix_t in_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      xwm_pkg::whl_t out_o
);

  localparam int QB = 17;
  localparam int NS = QB + 1;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  xwm_pkg::whl_t  pay_q [NS];
  logic [17:0]    rem_q [NS][4];
  logic [QB-1:0]  num_q [NS][4];
  logic [QB-1:0]  quo_q [NS][4];
  logic [17:0]    dv_q  [NS];

  // numerator 2*t*budget + peak, divisor 2*peak
  logic [35:0]    n0 [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n0[i] = {1'b0, in_i.prod[i], 1'b0} + 36'(in_i.peak_trans);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pay_q[0].neg   <= in_i.neg;
      pay_q[0].mag   <= in_i.mag;
      pay_q[0].turn  <= in_i.turn;
      pay_q[0].scale <= in_i.scale;
      dv_q[0]        <= {in_i.peak_trans, 1'b0};
      for (int i = 0; i < 4; i++) begin
        rem_q[0][i] <= n0[i][34:17];
        num_q[0][i] <= n0[i][16:0];
        quo_q[0][i] <= '0;
      end
    end
  end

  logic [18:0] trial [NS][4];
  logic        ge    [NS][4];
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int i = 0; i < 4; i++) begin
        trial[s][i] = {rem_q[s][i], num_q[s][i][QB-1]};
        ge[s][i]    = trial[s][i] >= {1'b0, dv_q[s]};
      end
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        pay_q[k] <= pay_q[k-1];
        dv_q[k]  <= dv_q[k-1];
        for (int i = 0; i < 4; i++) begin
          rem_q[k][i] <= ge[k-1][i] ? 18'(trial[k-1][i] - {1'b0, dv_q[k-1]})
                                    : trial[k-1][i][17:0];
          num_q[k][i] <= {num_q[k-1][i][QB-2:0], 1'b0};
          quo_q[k][i] <= {quo_q[k-1][i][QB-2:0], ge[k-1][i]};
        end
      end
    end
  end

  always_comb begin
    out_o = pay_q[NS-1];
    for (int i = 0; i < 4; i++) begin
      if (pay_q[NS-1].scale) out_o.mag[i] = quo_q[NS-1][i];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

endmodule
`default_nettype wire

// ===== sv/xwm_out.sv =====
// Output section: adds the turn, flags stopped wheels, converts to
// millivolts or percent with saturation. Uses xwm_pkg.
`default_nettype none
module xwm_out #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         out_mode_i,
  input  wire logic [7:0]         mv_scale_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire xwm_pkg::whl_t      in_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [17:0] cmd_o [4],
  output      logic [3:0]         stop_mask_o,
  output      logic               applied_o
);

  localparam int NS = 3;
  localparam logic [17:0] ONE  = 18'(1) << FRACTION_BITS;
  localparam logic [26:0] HALF = 27'(1) << (FRACTION_BITS - 1);

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // O0: wheel value
  logic signed [18:0] w0_q [4];
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        w0_q[i] <= (in_i.neg[i] ? -19'(in_i.mag[i]) : 19'(in_i.mag[i]))
                   + 19'(in_i.turn);
      end
    end
  end

  // O1: magnitude, stop flag, millivolt product
  logic [17:0]        wm1 [4];
  logic signed [18:0] w1_q [4];
  logic [3:0]         stop1_q;
  logic [25:0]        mvp1_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wm1[i] = w0_q[i][18] ? 18'(-w0_q[i]) : 18'(w0_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        w1_q[i]    <= w0_q[i];
        stop1_q[i] <= wm1[i] <= ONE;
        mvp1_q[i]  <= 26'(wm1[i]) * 26'(mv_scale_i);
      end
    end
  end

  // O2: convert, saturate, output register
  logic [26:0]        mvq2 [4];
  logic signed [17:0] pct2 [4];
  logic signed [17:0] mv2 [4];
  logic signed [17:0] cmd2 [4];
  logic               app2;

  always_comb begin
    app2 = (out_mode_i == xwm_pkg::OUT_MILLIVOLT) || (out_mode_i == xwm_pkg::OUT_PERCENT);
    for (int i = 0; i < 4; i++) begin
      mvq2[i] = (27'(mvp1_q[i]) + HALF) >> FRACTION_BITS;
      if (w1_q[i] > 19'sd131071)       pct2[i] = xwm_pkg::CMD_MAX;
      else if (w1_q[i] < -19'sd131072) pct2[i] = xwm_pkg::CMD_MIN;
      else                             pct2[i] = w1_q[i][17:0];
      if (w1_q[i][18]) begin
        mv2[i] = (mvq2[i] > 27'd131072) ? xwm_pkg::CMD_MIN : -mvq2[i][17:0];
      end else begin
        mv2[i] = (mvq2[i] > 27'd131071) ? xwm_pkg::CMD_MAX : mvq2[i][17:0];
      end
      if (stop1_q[i])                                 cmd2[i] = '0;
      else if (out_mode_i == xwm_pkg::OUT_PERCENT)    cmd2[i] = pct2[i];
      else if (out_mode_i == xwm_pkg::OUT_MILLIVOLT)  cmd2[i] = mv2[i];
      else                                            cmd2[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 4; i++) cmd_o[i] <= cmd2[i];
      stop_mask_o <= stop1_q;
      applied_o   <= app2;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

endmodule
`default_nettype wire

// ===== sv/xdrive_wheel_mixer.sv =====
// Four-wheel diagonal drive mixer: one command transaction in, four wheel
// commands out. Fully pipelined: a transaction can enter every cycle unless
// stalled (6 mixer stages, 18 divider stages of which all but the first
// resolve one quotient bit each, 3 output stages). A stall on the output
// holds the pipeline while empty stages still fill. Configuration registers
// are read live and should be written only while the pipeline is empty.
// Depends on xwm_pkg, xwm_mix, xwm_div, xwm_out.
`default_nettype none
module xdrive_wheel_mixer #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] auton_x_i,
  input  wire logic signed [15:0] auton_y_i,
  input  wire logic signed [15:0] auton_turn_i,
  input  wire logic signed [15:0] driver_x_i,
  input  wire logic signed [15:0] driver_y_i,
  input  wire logic signed [15:0] driver_turn_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [17:0] left_front_cmd_o,
  output      logic signed [17:0] left_back_cmd_o,
  output      logic signed [17:0] right_front_cmd_o,
  output      logic signed [17:0] right_back_cmd_o,
  output      logic [3:0]         stop_mask_o,
  output      logic               applied_o
);

  logic [1:0] prio_q, out_mode_q, brake_q;
  logic [7:0] mv_scale_q;

  // brake kind is held for software only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q     <= '0;
      out_mode_q <= '0;
      brake_q    <= '0;
      mv_scale_q <= xwm_pkg::MV_SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xwm_pkg::CFG_PRIORITY: prio_q     <= cfg_data_i[1:0];
        xwm_pkg::CFG_OUTPUT:   out_mode_q <= cfg_data_i[1:0];
        xwm_pkg::CFG_BRAKE:    brake_q    <= cfg_data_i[1:0];
        xwm_pkg::CFG_MV_SCALE: mv_scale_q <= cfg_data_i;
        default:               mv_scale_q <= mv_scale_q;
      endcase
    end
  end

  logic          mix_rdy, mix_vld, div_rdy, div_vld, out_rdy;
  xwm_pkg::mix_t mix_d;
  xwm_pkg::whl_t whl_d;
  logic signed [17:0] cmd [4];

  xwm_mix #(.FRACTION_BITS(FRACTION_BITS)) u_mix (
    .clk_i, .rst_ni,
    .prio_i        (prio_q),
    .in_valid_i,
    .in_ready_o    (mix_rdy),
    .auton_x_i, .auton_y_i, .auton_turn_i,
    .driver_x_i, .driver_y_i, .driver_turn_i,
    .out_valid_o   (mix_vld),
    .out_ready_i   (div_rdy),
    .out_o         (mix_d)
  );

  xwm_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i    (mix_vld),
    .in_ready_o    (div_rdy),
    .in_i          (mix_d),
    .out_valid_o   (div_vld),
    .out_ready_i   (out_rdy),
    .out_o         (whl_d)
  );

  xwm_out #(.FRACTION_BITS(FRACTION_BITS)) u_out (
    .clk_i, .rst_ni,
    .out_mode_i    (out_mode_q),
    .mv_scale_i    (mv_scale_q),
    .in_valid_i    (div_vld),
    .in_ready_o    (out_rdy),
    .in_i          (whl_d),
    .out_valid_o,
    .out_stall_i,
    .cmd_o         (cmd),
    .stop_mask_o,
    .applied_o
  );

  assign in_stall_o        = !mix_rdy;
  assign left_front_cmd_o  = cmd[0];
  assign left_back_cmd_o   = cmd[1];
  assign right_front_cmd_o = cmd[2];
  assign right_back_cmd_o  = cmd[3];

endmodule
`default_nettype wire

// ===== sim/tb_xdrive_wheel_mixer.sv =====
// Testbench for the wheel mixer: random and directed command transactions,
// predicted in a scoreboard class and checked against the block's results.
// Depends on xwm_pkg and xdrive_wheel_mixer.
`default_nettype none
module tb_xdrive_wheel_mixer;

  localparam int FB = 8;
  localparam int LATENCY = 27;

  typedef struct {
    logic signed [17:0] cmd [4];
    logic [3:0] mask;
    logic applied;
  } wheels_t;

  class wheel_scoreboard;
    logic [1:0] prio_mode;
    logic [1:0] out_mode;
    logic [7:0] mv_scale;
    wheels_t pending[$];
    int errors;

    function new();
      prio_mode = 2'd0;
      out_mode = xwm_pkg::OUT_MILLIVOLT;
      mv_scale = xwm_pkg::MV_SCALE_RESET;
      errors = 0;
    endfunction

    function longint rnd_shift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    function longint sat(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
    endfunction

    function longint absl(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void note_command(logic signed [15:0] ax, ay, at, dx, dy, dt);
      longint x, y, turn, hundred, budget, w, c;
      longint tr[4];
      longint peak_trans, max_raw;
      wheels_t r;
      hundred = 100 <<< FB;
      x = longint'(ax) + longint'(dx);
      y = longint'(ay) + longint'(dy);
      turn = longint'(at) + longint'(dt);
      tr[0] = rnd_shift((y - x) * 46341, 16);
      tr[1] = rnd_shift((-x - y) * 46341, 16);
      tr[2] = rnd_shift((x + y) * 46341, 16);
      tr[3] = rnd_shift((x - y) * 46341, 16);
      peak_trans = 0;
      max_raw = 0;
      for (int i = 0; i < 4; i++) begin
        if (absl(tr[i]) > peak_trans) peak_trans = absl(tr[i]);
        if (absl(tr[i] + turn) > max_raw) max_raw = absl(tr[i] + turn);
      end
      if (max_raw > hundred) begin
        if (prio_mode == xwm_pkg::PRIO_KEEP_TRANS && turn != 0) begin
          budget = hundred - peak_trans;
          if (budget < 0) budget = 0;
          if (budget < absl(turn)) turn = (turn < 0) ? -budget : budget;
        end else if (prio_mode == xwm_pkg::PRIO_KEEP_TURN && peak_trans != 0) begin
          budget = hundred - absl(turn);
          if (budget < 0) budget = 0;
          if (budget < peak_trans)
            for (int i = 0; i < 4; i++) begin
              c = (absl(tr[i]) * budget * 2 + peak_trans) / (peak_trans * 2);
              tr[i] = (tr[i] < 0) ? -c : c;
            end
        end
      end
      r.mask = 4'd0;
      r.applied = (out_mode == xwm_pkg::OUT_MILLIVOLT || out_mode == xwm_pkg::OUT_PERCENT);
      for (int i = 0; i < 4; i++) begin
        w = tr[i] + turn;
        c = 0;
        if (absl(w) <= (64'sd1 <<< FB)) r.mask[i] = 1'b1;
        else if (out_mode == xwm_pkg::OUT_PERCENT) c = sat(w);
        else if (out_mode == xwm_pkg::OUT_MILLIVOLT) c = sat(rnd_shift(w * mv_scale, FB));
        r.cmd[i] = c[17:0];
      end
      pending.push_back(r);
    endfunction

    function void check_wheels(wheels_t got);
      wheels_t e;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction");
        return;
      end
      e = pending.pop_front();
      bad = (got.mask !== e.mask) || (got.applied !== e.applied);
      for (int i = 0; i < 4; i++) if (got.cmd[i] !== e.cmd[i]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %0d %0d %0d %0d m%h a%b got %0d %0d %0d %0d m%h a%b",
                   e.cmd[0], e.cmd[1], e.cmd[2], e.cmd[3], e.mask, e.applied,
                   got.cmd[0], got.cmd[1], got.cmd[2], got.cmd[3], got.mask,
                   got.applied);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] auton_x_i = '0, auton_y_i = '0, auton_turn_i = '0;
  logic signed [15:0] driver_x_i = '0, driver_y_i = '0, driver_turn_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [17:0] left_front_cmd_o, left_back_cmd_o;
  logic signed [17:0] right_front_cmd_o, right_back_cmd_o;
  logic [3:0] stop_mask_o;
  logic applied_o;

  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;
  wheel_scoreboard sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  xdrive_wheel_mixer #(.FRACTION_BITS(FB)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .auton_x_i, .auton_y_i, .auton_turn_i, .driver_x_i, .driver_y_i, .driver_turn_i,
    .out_valid_o, .out_stall_i,
    .left_front_cmd_o, .left_back_cmd_o, .right_front_cmd_o, .right_back_cmd_o,
    .stop_mask_o, .applied_o
  );

  // receiver side: random stall, check on accept
  always @(posedge clk_i) begin
    wheels_t got;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.cmd[0] = left_front_cmd_o;
      got.cmd[1] = left_back_cmd_o;
      got.cmd[2] = right_front_cmd_o;
      got.cmd[3] = right_back_cmd_o;
      got.mask = stop_mask_o;
      got.applied = applied_o;
      sb.check_wheels(got);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (cycles > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      xwm_pkg::CFG_PRIORITY: sb.prio_mode = val[1:0];
      xwm_pkg::CFG_OUTPUT:   sb.out_mode = val[1:0];
      xwm_pkg::CFG_MV_SCALE: sb.mv_scale = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // one transaction: optional idle gaps, then hold until accepted
  task automatic send(logic signed [15:0] ax, ay, at, dx, dy, dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    auton_x_i <= ax; auton_y_i <= ay; auton_turn_i <= at;
    driver_x_i <= dx; driver_y_i <= dy; driver_turn_i <= dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(ax, ay, at, dx, dy, dt);
  endtask

  function automatic logic signed [15:0] rand_field(int sel);
    case (sel)
      0: return 16'($urandom_range(25600 * 2) - 25600);
      1: return 16'($urandom_range(1024) - 512);   // near the stop threshold
      2: return 16'(int'($urandom_range(65535)));  // any bit pattern
      default: return 16'($urandom_range(6000) - 3000);
    endcase
  endfunction

  task automatic random_phase(int n);
    int s;
    for (int k = 0; k < n; k++) begin
      s = $urandom_range(3);
      send(rand_field(s), rand_field(s), rand_field($urandom_range(3)),
           rand_field(s), rand_field(s), rand_field($urandom_range(3)));
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int idle_set[5] = '{0, 85, 0, 23, 0};
    int stall_set[5] = '{0, 0, 85, 23, 0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes and stop threshold at reset config
    send(16'sd25600, 16'sd25600, 16'sd25600, 16'sd25600, 16'sd25600, 16'sd25600);
    send(-16'sd25600, -16'sd25600, -16'sd25600, -16'sd25600, -16'sd25600, -16'sd25600);
    send(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send(16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0);
    send(16'sd0, 16'sd0, 16'sd257, 16'sd0, 16'sd0, 16'sd0);
    send(16'sd0, 16'sd0, -16'sd256, 16'sd0, 16'sd0, -16'sd1);
    send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    in_valid_i <= 1'b0;
    drain();
    for (int p = 0; p < 12; p++) begin
      write_reg(xwm_pkg::CFG_PRIORITY, 8'(p % 4));
      write_reg(xwm_pkg::CFG_OUTPUT, 8'((p / 4 + p) % 4));
      write_reg(xwm_pkg::CFG_BRAKE, 8'($urandom_range(3)));
      write_reg(xwm_pkg::CFG_MV_SCALE,
                (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom_range(255)));
      // directed per setting: heavy turn with translation, pure translation
      send(16'sd25600, 16'sd25600, 16'sd20000, 16'sd0, 16'sd0, 16'sd25600);
      send(16'sd20000, 16'sd0, -16'sd12000, 16'sd0, 16'sd0, 16'sd0);
      send(16'sd25600, -16'sd25600, 16'sd0, 16'sd25600, -16'sd25600, 16'sd0);
      send_idle_pct = idle_set[p % 5];
      stall_pct = stall_set[p % 5];
      random_phase(72);
      if (p == 6) drain();  // sender holds off until all results are in
      send_idle_pct = 0;
      stall_pct = 0;
      drain();
    end
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/xwm_pkg.sv
sv/xwm_mix.sv
sv/xwm_div.sv
sv/xwm_out.sv
sv/xdrive_wheel_mixer.sv
sim/tb_xdrive_wheel_mixer.sv
